FILE: rtl/core/jd2d_pkg.sv
package jd2d_pkg;

	localparam int unsigned JD_W     = 25;
	localparam int unsigned IN_W     = 32;
	localparam int unsigned OUT_W    = 32;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned DOM_W    = 5;
	localparam int unsigned YEAR_W   = 16;
	localparam int unsigned WDAY_W   = 3;

	localparam logic [JD_W-1:0] DAY_MIN = 25'd1721120;
	localparam logic [JD_W-1:0] DAY_MAX = 25'd25657575;

	localparam int unsigned DAYS_4000Y  = 1460969;
	localparam int unsigned DAYS_400Y   = 146097;
	localparam int unsigned DAYS_4Y     = 1461;
	localparam int unsigned MONTH_SPAN5 = 153;
	localparam int unsigned WEEK_DAYS   = 7;
	localparam int unsigned YEARS_4000  = 4000;
	localparam int unsigned YEARS_100   = 100;

	// floor(2^k / divisor), k = width of the dividend
	localparam int unsigned RECIP_4000Y = (1 << 25) / DAYS_4000Y;
	localparam int unsigned RECIP_WEEK  = (1 << 25) / WEEK_DAYS;
	localparam int unsigned RECIP_400Y  = (1 << 23) / DAYS_400Y;
	localparam int unsigned RECIP_4Y    = (1 << 18) / DAYS_4Y;
	localparam int unsigned RECIP_SPAN5 = (1 << 11) / MONTH_SPAN5;
	// x / 5 as (x * 205) >> 10, exact for x below 1024
	localparam int unsigned RECIP_5     = 205;

endpackage

FILE: rtl/core/julian_day_to_date_unit.sv
// Julian day number to Gregorian date converter.
// Input stream (s_axis_*): one transaction carries one Julian day number.
// Output stream (m_axis_*): one transaction per input, with month, day of
// month, year and weekday (1 Sunday .. 7 Saturday) in tdata and the range
// flag in tuser. Day numbers outside 1721120 .. 25657575 give all-zero
// date fields and a clear flag.
// Throughput is one transaction per cycle while m_axis_tready does not hold
// the output: the constant divisions are reciprocal multiplies, split over
// four pairs of stages (estimate, then remainder with one correction), the
// weekday division sharing the 4000-year pair, plus an input stage and a
// final month and day stage.
// Reset clears all stage valid bits, so the pipeline comes up empty.
// When the receiver holds m_axis_tready low while a result is waiting, the
// whole pipeline freezes and s_axis_tready drops; nothing is lost or
// repeated, and bubbles advance freely while the output is empty.
module julian_day_to_date_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// [24:0] julian_day, [31:25] zero
	input  logic [jd2d_pkg::IN_W-1:0] s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// [3:0] month, [8:4] day_of_month, [24:9] year, [27:25] weekday, [31:28] zero
	output logic [jd2d_pkg::OUT_W-1:0] m_axis_tdata,
	// [0] valid_res
	output logic                      m_axis_tuser
);

	logic advance;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;

	logic [24:0] a_s1, a_s2, w_s1, w_s2;
	logic        ok_s1, ok_s2, ok_s3, ok_s4, ok_s5, ok_s6, ok_s7, ok_s8, ok_s9;
	logic [4:0]  qe1_s2, q1_s3, q1_s4;
	logic [22:0] qw_s2;
	logic [2:0]  wd_s3, wd_s4, wd_s5, wd_s6, wd_s7, wd_s8, wd_s9;
	logic [22:0] n3_s3, n3_s4;
	logic [5:0]  qe2_s4;
	logic [17:0] quad_s5, quad_s6;
	logic [16:0] yy_s5, yy_s6, yy_s7, yy_s8, yy_s9;
	logic [6:0]  qe3_s6;
	logic [10:0] t_s7, t_s8;
	logic [3:0]  qe4_s8, m_s9;
	logic [7:0]  r4_s9;

	logic [3:0]  month_s10;
	logic [4:0]  dom_s10;
	logic [15:0] year_s10;
	logic [2:0]  wd_s10;
	logic        ok_s10;

	logic [24:0] jd_in;
	logic [29:0] p1;
	logic [47:0] pw;
	logic [24:0] r1_raw, r7_raw;
	logic [20:0] r1;
	logic [3:0]  r7;
	logic [4:0]  q1;
	logic [28:0] p2;
	logic [22:0] r2_raw;
	logic [17:0] rem2;
	logic [5:0]  c;
	logic [25:0] p3;
	logic [17:0] r3_raw;
	logic [10:0] rem3;
	logic [6:0]  q3;
	logic [14:0] p4;
	logic [10:0] r4_raw;
	logic [7:0]  r4;
	logic [3:0]  m;
	logic [14:0] dp;
	logic [3:0]  mon;
	logic [16:0] yr;

	assign advance       = !v_s10 || m_axis_tready;
	assign s_axis_tready = advance;
	assign m_axis_tvalid = v_s10;
	assign m_axis_tdata  = {4'd0, wd_s10, year_s10, dom_s10, month_s10};
	assign m_axis_tuser  = ok_s10;
	assign jd_in         = s_axis_tdata[24:0];

	always_comb begin
		// 4000-year split and weekday
		p1 = 30'(a_s1) * 30'(jd2d_pkg::RECIP_4000Y);
		pw = 48'(w_s1) * 48'(jd2d_pkg::RECIP_WEEK);

		r1_raw = a_s2 - 25'(25'(qe1_s2) * 25'(jd2d_pkg::DAYS_4000Y));
		if (r1_raw >= 25'(jd2d_pkg::DAYS_4000Y)) begin
			q1 = qe1_s2 + 5'd1;
			r1 = 21'(r1_raw - 25'(jd2d_pkg::DAYS_4000Y));
		end else begin
			q1 = qe1_s2;
			r1 = r1_raw[20:0];
		end
		r7_raw = w_s2 - 25'(25'(qw_s2) * 25'(jd2d_pkg::WEEK_DAYS));
		if (r7_raw[3:0] >= 4'(jd2d_pkg::WEEK_DAYS)) begin
			r7 = r7_raw[3:0] - 4'(jd2d_pkg::WEEK_DAYS);
		end else begin
			r7 = r7_raw[3:0];
		end

		// 400-year split
		p2 = 29'(n3_s3) * 29'(jd2d_pkg::RECIP_400Y);
		r2_raw = n3_s4 - 23'(23'(qe2_s4) * 23'(jd2d_pkg::DAYS_400Y));
		if (r2_raw >= 23'(jd2d_pkg::DAYS_400Y)) begin
			c    = qe2_s4 + 6'd1;
			rem2 = 18'(r2_raw - 23'(jd2d_pkg::DAYS_400Y));
		end else begin
			c    = qe2_s4;
			rem2 = r2_raw[17:0];
		end

		// 4-year split
		p3 = 26'(quad_s5) * 26'(jd2d_pkg::RECIP_4Y);
		r3_raw = quad_s6 - 18'(18'(qe3_s6) * 18'(jd2d_pkg::DAYS_4Y));
		if (r3_raw >= 18'(jd2d_pkg::DAYS_4Y)) begin
			q3   = qe3_s6 + 7'd1;
			rem3 = 11'(r3_raw - 18'(jd2d_pkg::DAYS_4Y));
		end else begin
			q3   = qe3_s6;
			rem3 = r3_raw[10:0];
		end

		// month split, counted from march
		p4 = 15'(t_s7) * 15'(jd2d_pkg::RECIP_SPAN5);
		r4_raw = t_s8 - 11'(11'(qe4_s8) * 11'(jd2d_pkg::MONTH_SPAN5));
		if (r4_raw >= 11'(jd2d_pkg::MONTH_SPAN5)) begin
			m  = qe4_s8 + 4'd1;
			r4 = 8'(r4_raw - 11'(jd2d_pkg::MONTH_SPAN5));
		end else begin
			m  = qe4_s8;
			r4 = r4_raw[7:0];
		end

		// day of month and shift back to january-based months
		dp = 15'(r4_s9 + 8'd5) * 15'(jd2d_pkg::RECIP_5);
		if (m_s9 < 4'd10) begin
			mon = m_s9 + 4'd3;
			yr  = yy_s9;
		end else begin
			mon = m_s9 - 4'd9;
			yr  = yy_s9 + 17'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (advance) begin
			v_s1  <= s_axis_tvalid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			a_s1  <= jd_in - jd2d_pkg::DAY_MIN;
			w_s1  <= jd_in + 25'd1;
			ok_s1 <= (jd_in >= jd2d_pkg::DAY_MIN) && (jd_in <= jd2d_pkg::DAY_MAX);

			qe1_s2 <= p1[29:25];
			qw_s2  <= pw[47:25];
			a_s2   <= a_s1;
			w_s2   <= w_s1;
			ok_s2  <= ok_s1;

			q1_s3 <= q1;
			n3_s3 <= {r1, 2'b11};
			wd_s3 <= 3'(r7 + 4'd1);
			ok_s3 <= ok_s2;

			qe2_s4 <= p2[28:23];
			n3_s4  <= n3_s3;
			q1_s4  <= q1_s3;
			wd_s4  <= wd_s3;
			ok_s4  <= ok_s3;

			quad_s5 <= rem2 | 18'd3;
			yy_s5   <= 17'(17'(q1_s4) * 17'(jd2d_pkg::YEARS_4000))
				+ 17'(17'(c) * 17'(jd2d_pkg::YEARS_100));
			wd_s5   <= wd_s4;
			ok_s5   <= ok_s4;

			qe3_s6  <= p3[24:18];
			quad_s6 <= quad_s5;
			yy_s6   <= yy_s5;
			wd_s6   <= wd_s5;
			ok_s6   <= ok_s5;

			t_s7  <= 11'(11'd5 * (11'(rem3[10:2]) + 11'd1) - 11'd3);
			yy_s7 <= yy_s6 + 17'(q3);
			wd_s7 <= wd_s6;
			ok_s7 <= ok_s6;

			qe4_s8 <= p4[14:11];
			t_s8   <= t_s7;
			yy_s8  <= yy_s7;
			wd_s8  <= wd_s7;
			ok_s8  <= ok_s7;

			m_s9  <= m;
			r4_s9 <= r4;
			yy_s9 <= yy_s8;
			wd_s9 <= wd_s8;
			ok_s9 <= ok_s8;

			month_s10 <= ok_s9 ? mon : 4'd0;
			dom_s10   <= ok_s9 ? dp[14:10] : 5'd0;
			year_s10  <= ok_s9 ? yr[15:0] : 16'd0;
			wd_s10    <= ok_s9 ? wd_s9 : 3'd0;
			ok_s10    <= ok_s9;
		end
	end

endmodule
